@@ design/att_pkg.sv @@
// att_pkg: shared types and constants for the allocation tracking table.
// No dependencies.

package att_pkg;

   localparam int SIZE_W  = 32;
   localparam int SLOT_W  = 10;
   localparam int COUNT_W = 11;
   localparam int TOTAL_W = 43;
   localparam int STAT_W  = 2;

   localparam logic CMD_RECORD  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] live_count;
      logic [TOTAL_W-1:0] live_bytes;
   } rsp_type;

endpackage

@@ design/allocation_tracking_table_top.sv @@
// A zero address skips the table scan; a hit at slot k ends the scan at that entry; a miss
// scans the whole table. One table entry is checked per cycle through the memory read port.
// Throughput: one item per scan; the next item is taken once the result moves to the
// output register, which may still be waiting on the consumer.
// Reset (synchronous, active high) starts a clear pass that zeroes every table entry;
// no beat is accepted until it completes.

module allocation_tracking_table_top #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ADDR_BITS   = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [ADDR_BITS-1:0]           req_address,
   input  logic [att_pkg::SIZE_W-1:0]     req_alloc_bytes,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [att_pkg::STAT_W-1:0]     rsp_status,
   output logic [att_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [att_pkg::COUNT_W-1:0]    rsp_live_count,
   output logic [att_pkg::TOTAL_W-1:0]    rsp_live_bytes
);
   import att_pkg::*;

   logic    res_valid;
   logic    res_take;
   rsp_type res;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   att_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_BITS   (ADDR_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .req_alloc_bytes (req_alloc_bytes),
      .res_valid       (res_valid),
      .res_take        (res_take),
      .res             (res)
   );

   // output beat register frees when empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_slot       = rsp_ff.slot;
   assign rsp_live_count = rsp_ff.live_count;
   assign rsp_live_bytes = rsp_ff.live_bytes;

endmodule

@@ design/att_mem.sv @@
// att_mem: single-port-write, single-port-read table storage, registered read.
// No dependencies.

module att_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 81,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/att_match.sv @@
// att_match: shared entry compare and counter update unit.
// Depends on att_pkg.

module att_match #(
   parameter int ADDR_BITS = 48
) (
   input  logic                           cmd,
   input  logic [ADDR_BITS-1:0]           addr,
   input  logic [att_pkg::SIZE_W-1:0]     bytes,
   input  logic                           ent_valid,
   input  logic [ADDR_BITS-1:0]           ent_addr,
   input  logic [att_pkg::SIZE_W-1:0]     ent_size,
   input  logic [att_pkg::COUNT_W-1:0]    count,
   input  logic [att_pkg::TOTAL_W-1:0]    total,
   output logic                           hit,
   output logic [att_pkg::COUNT_W-1:0]    count_nxt,
   output logic [att_pkg::TOTAL_W-1:0]    total_nxt
);
   import att_pkg::*;

   always_comb begin
      if (cmd == CMD_RECORD) begin
         hit       = !ent_valid;
         count_nxt = count + COUNT_W'(1);
         total_nxt = total + TOTAL_W'(bytes);
      end else begin
         hit       = ent_valid && (ent_addr == addr);
         count_nxt = count - COUNT_W'(1);
         total_nxt = total - TOTAL_W'(ent_size);
      end
   end

endmodule

@@ design/att_ctrl.sv @@
// att_ctrl: sequencer for clear pass and per-item table scan, holds counters.
// Depends on att_pkg, att_mem, att_match.

module att_ctrl #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ADDR_BITS   = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [ADDR_BITS-1:0]         req_address,
   input  logic [att_pkg::SIZE_W-1:0]   req_alloc_bytes,
   output logic                         res_valid,
   input  logic                         res_take,
   output att_pkg::rsp_type             res
);
   import att_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENT_W = 1 + ADDR_BITS + SIZE_W;
   localparam int SX_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W:0]   DEPTH_C = (IDX_W+1)'(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_RESULT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W:0]       rd_idx_ff, rd_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [SIZE_W-1:0]    bytes_ff, bytes_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [STAT_W-1:0]    stat_ff, stat_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENT_W-1:0]     wr_data;
   logic                 rd_en;
   logic [ENT_W-1:0]     rd_data;
   logic                 hit;
   logic [COUNT_W-1:0]   count_nxt;
   logic [TOTAL_W-1:0]   total_nxt;
   logic [SX_W-1:0]      chk_ext;
   logic                 accept;

   att_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENT_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   att_match #(
      .ADDR_BITS (ADDR_BITS)
   ) u_match (
      .cmd       (cmd_ff),
      .addr      (addr_ff),
      .bytes     (bytes_ff),
      .ent_valid (rd_data[ENT_W-1]),
      .ent_addr  (rd_data[SIZE_W +: ADDR_BITS]),
      .ent_size  (rd_data[SIZE_W-1:0]),
      .count     (count_ff),
      .total     (total_ff),
      .hit       (hit),
      .count_nxt (count_nxt),
      .total_nxt (total_nxt)
   );

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign chk_ext   = SX_W'(chk_idx_ff);
   assign rd_en     = (state_ff == S_SCAN) && (rd_idx_ff < DEPTH_C);

   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      chk_vld_in = chk_vld_ff;
      chk_idx_in = chk_idx_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      bytes_in   = bytes_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      stat_in    = stat_ff;
      slot_in    = slot_ff;
      wr_en      = 1'b0;
      wr_addr    = rd_idx_ff[IDX_W-1:0];
      wr_data    = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en     = 1'b1;
            rd_idx_in = rd_idx_ff + (IDX_W+1)'(1);
            if (rd_idx_ff[IDX_W-1:0] == LAST_C) begin
               rd_idx_in = '0;
               state_in  = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               addr_in    = req_address;
               bytes_in   = req_alloc_bytes;
               rd_idx_in  = '0;
               chk_vld_in = 1'b0;
               if (req_address == '0) begin
                  stat_in  = STAT_OK;
                  slot_in  = '0;
                  state_in = S_RESULT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            chk_vld_in = rd_en;
            chk_idx_in = rd_idx_ff[IDX_W-1:0];
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + (IDX_W+1)'(1);
            end
            if (chk_vld_ff) begin
               if (hit) begin
                  wr_en    = 1'b1;
                  wr_addr  = chk_idx_ff;
                  wr_data  = (cmd_ff == CMD_RECORD) ? {1'b1, addr_ff, bytes_ff} : '0;
                  count_in = count_nxt;
                  total_in = total_nxt;
                  stat_in  = STAT_OK;
                  slot_in  = chk_ext[SLOT_W-1:0];
                  state_in = S_RESULT;
               end else if (chk_idx_ff == LAST_C) begin
                  stat_in  = (cmd_ff == CMD_RECORD) ? STAT_FULL : STAT_MISSING;
                  slot_in  = '0;
                  state_in = S_RESULT;
               end
            end
         end
         S_RESULT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         rd_idx_ff  <= '0;
         chk_vld_ff <= 1'b0;
         count_ff   <= '0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         rd_idx_ff  <= rd_idx_in;
         chk_vld_ff <= chk_vld_in;
         count_ff   <= count_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      cmd_ff     <= cmd_in;
      addr_ff    <= addr_in;
      bytes_ff   <= bytes_in;
      stat_ff    <= stat_in;
      slot_ff    <= slot_in;
   end

   assign res_valid      = (state_ff == S_RESULT);
   assign res.status     = stat_ff;
   assign res.slot       = slot_ff;
   assign res.live_count = count_ff;
   assign res.live_bytes = total_ff;

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for allocation_tracking_table_top, driving record and release beats.
// Keeps its own copy of the table to predict each result. Depends on att_pkg and the top level.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import att_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int ADDR_W    = 48;
   localparam int N_RANDOM  = 560;
   localparam int HOLD_LEN  = 3000;
   localparam int LIMIT     = 8000000;
   localparam int SHOW_MAX  = 10;

   typedef struct {
      logic              cmd;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] bytes;
   } beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = CMD_RECORD;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [SIZE_W-1:0]   req_alloc_bytes = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [COUNT_W-1:0]  rsp_live_count;
   logic [TOTAL_W-1:0]  rsp_live_bytes;

   allocation_tracking_table_top #(
      .TABLE_DEPTH(DEPTH),
      .ADDR_BITS  (ADDR_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_address    (req_address),
      .req_alloc_bytes(req_alloc_bytes),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot       (rsp_slot),
      .rsp_live_count (rsp_live_count),
      .rsp_live_bytes (rsp_live_bytes)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the tracking table
   logic                slot_used [DEPTH];
   logic [ADDR_W-1:0]   slot_addr [DEPTH];
   logic [SIZE_W-1:0]   slot_size [DEPTH];
   logic [COUNT_W-1:0]  live_n = '0;
   logic [TOTAL_W-1:0]  live_sum = '0;

   beat_type            req_backlog [$];
   rsp_type             pending_rsp [$];
   logic [ADDR_W-1:0]   gen_live [$];
   beat_type            next_beat;
   int                  n_queued = 0;
   int                  n_taken = 0;
   int                  bad_n = 0;
   int                  snd_idle_pct = 0;
   int                  rcv_stall_pct = 0;
   logic                hold_go = 1'b0;
   int                  hold_cnt = 0;
   int unsigned         cyc_n = 0;
   wire                 hold_on = hold_go && (hold_cnt < HOLD_LEN);

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_used[i] = 1'b0;
         slot_addr[i] = '0;
         slot_size[i] = '0;
      end
   end

   function automatic rsp_type track_beat(logic cmd, logic [ADDR_W-1:0] a,
                                          logic [SIZE_W-1:0] b);
      rsp_type r;
      int      hit;
      hit = -1;
      r.status = STAT_OK;
      r.slot   = '0;
      if (a != '0) begin
         if (cmd == CMD_RECORD) begin
            for (int i = 0; i < DEPTH && hit < 0; i++)
               if (!slot_used[i]) hit = i;
            if (hit < 0) begin
               r.status = STAT_FULL;
            end else begin
               slot_used[hit] = 1'b1;
               slot_addr[hit] = a;
               slot_size[hit] = b;
               live_n   = live_n + COUNT_W'(1);
               live_sum = live_sum + TOTAL_W'(b);
               r.slot   = SLOT_W'(hit);
            end
         end else begin
            for (int i = 0; i < DEPTH && hit < 0; i++)
               if (slot_used[i] && slot_addr[i] == a) hit = i;
            if (hit < 0) begin
               r.status = STAT_MISSING;
            end else begin
               live_sum = live_sum - TOTAL_W'(slot_size[hit]);
               live_n   = live_n - COUNT_W'(1);
               slot_used[hit] = 1'b0;
               slot_addr[hit] = '0;
               slot_size[hit] = '0;
               r.slot   = SLOT_W'(hit);
            end
         end
      end
      r.live_count = live_n;
      r.live_bytes = live_sum;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_rsp.push_back(track_beat(req_cmd, req_address, req_alloc_bytes));
            n_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               next_beat = req_backlog.pop_front();
               req_valid       <= 1'b1;
               req_cmd         <= next_beat.cmd;
               req_address     <= next_beat.address;
               req_alloc_bytes <= next_beat.bytes;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : monitor
      rsp_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_slot, rsp_live_count, rsp_live_bytes};
            if (pending_rsp.size() == 0) begin
               if (bad_n < SHOW_MAX)
                  $display("unexpected beat: status %0d slot %0d count %0d bytes %0h",
                           got.status, got.slot, got.live_count, got.live_bytes);
               bad_n++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.live_count !== want.live_count ||
                   got.live_bytes !== want.live_bytes) begin
                  if (bad_n < SHOW_MAX)
                     $display("mismatch: exp %0d %0d %0d %0h, got %0d %0d %0d %0h",
                              want.status, want.slot, want.live_count, want.live_bytes,
                              got.status, got.slot, got.live_count, got.live_bytes);
                  bad_n++;
               end
            end
         end
         rsp_stall <= hold_on || ($urandom_range(99) < rcv_stall_pct);
      end
   end

   // long back-pressure stretch
   always @(posedge clock) begin
      if (hold_on) hold_cnt <= hold_cnt + 1;
   end

   always @(posedge clock) begin
      cyc_n <= cyc_n + 1;
      if (cyc_n == LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      if (w[ADDR_W-1:0] == '0) w = 64'd1;
      return w[ADDR_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] rand_bytes();
      int r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   task automatic queue_beat(logic cmd, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] b);
      int k;
      k = -1;
      req_backlog.push_back(beat_type'{cmd, a, b});
      n_queued++;
      if (a != '0) begin
         if (cmd == CMD_RECORD) begin
            gen_live.push_back(a);
         end else begin
            foreach (gen_live[i])
               if (k < 0 && gen_live[i] == a) k = i;
            if (k >= 0) gen_live.delete(k);
         end
      end
   endtask

   task automatic wait_drained();
      while (n_taken != n_queued || pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic random_beats(int n);
      int r;
      for (int j = 0; j < n; j++) begin
         r = $urandom_range(99);
         if (r < 4)
            queue_beat(1'($urandom_range(1)), '0, $urandom);
         else if (r < 12)
            queue_beat(CMD_RELEASE, rand_addr(), $urandom);
         else if (r < 18 && gen_live.size() != 0)
            queue_beat(CMD_RECORD, gen_live[$urandom_range(gen_live.size()-1)], rand_bytes());
         else if (gen_live.size() == 0 || $urandom_range(31) >= gen_live.size())
            queue_beat(CMD_RECORD, rand_addr(), rand_bytes());
         else
            queue_beat(CMD_RELEASE, gen_live[$urandom_range(gen_live.size()-1)], $urandom);
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored zero address, miss on empty table, duplicates, extremes
      queue_beat(CMD_RECORD,  '0, '1);
      queue_beat(CMD_RELEASE, '0, 32'h1234_5678);
      queue_beat(CMD_RELEASE, 48'h0000_0000_0123, '0);
      queue_beat(CMD_RECORD,  '1, '1);
      queue_beat(CMD_RECORD,  48'd1, '0);
      queue_beat(CMD_RECORD,  48'h0000_00AB_CDEF, 32'd1);
      queue_beat(CMD_RECORD,  48'd1, 32'd5);
      queue_beat(CMD_RELEASE, 48'd1, '1);
      queue_beat(CMD_RECORD,  48'h5555_5555_5555, 32'h8000_0000);
      queue_beat(CMD_RELEASE, 48'd1, '0);
      queue_beat(CMD_RELEASE, 48'd1, '0);
      queue_beat(CMD_RECORD,  '0, 32'hDEAD_BEEF);
      queue_beat(CMD_RELEASE, '1, '0);
      queue_beat(CMD_RECORD,  48'h8000_0000_0000, 32'h7FFF_FFFF);
      queue_beat(CMD_RECORD,  48'hAAAA_AAAA_AAAA, 32'h5555_5555);
      queue_beat(CMD_RELEASE, 48'h0000_00AB_CDEF, '1);
      queue_beat(CMD_RELEASE, 48'h5555_5555_5555, '0);
      queue_beat(CMD_RELEASE, 48'h8000_0000_0000, '0);
      queue_beat(CMD_RELEASE, 48'hAAAA_AAAA_AAAA, '0);
      queue_beat(CMD_RELEASE, 48'hAAAA_AAAA_AAAB, '0);
      wait_drained();

      snd_idle_pct = 0;  rcv_stall_pct = 0;
      random_beats(N_RANDOM / 4);
      wait_drained();
      snd_idle_pct = 72; rcv_stall_pct = 0;
      random_beats(N_RANDOM / 4);
      wait_drained();
      snd_idle_pct = 0;  rcv_stall_pct = 72;
      hold_go = 1'b1;
      random_beats(N_RANDOM / 4);
      wait_drained();
      snd_idle_pct = 17; rcv_stall_pct = 17;
      random_beats(N_RANDOM / 4);

      // tail: freed slot reuse, miss, zero address
      if (gen_live.size() != 0)
         queue_beat(CMD_RELEASE, gen_live[$urandom_range(gen_live.size()-1)], '0);
      queue_beat(CMD_RECORD, rand_addr(), '1);
      queue_beat(CMD_RECORD, rand_addr(), '1);
      queue_beat(CMD_RELEASE, rand_addr(), '0);
      queue_beat(CMD_RELEASE, '0, '1);

      wait_drained();
      repeat (DEPTH + 16) @(posedge clock);
      if (bad_n == 0 && pending_rsp.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
